### hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and divisor tables for the tone prescale select
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  // Width of the doubled frequency, which is the divisor of the cell chain.
  localparam int unsigned DVSR_W = 15;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned CMP_W  = 16;

  // Prescaler codes with a meaning of their own.
  localparam logic [CODE_W-1:0] CODE_STOP     = 4'd0;
  localparam logic [CODE_W-1:0] CODE_FIRST    = 4'd1;
  localparam logic [CODE_W-1:0] TABLE_SIZE_16 = 4'd6;
  localparam logic [CODE_W-1:0] TABLE_SIZE_8  = 4'd8;

  // Timer limits, as counts that still fit.
  localparam logic [31:0] LIMIT_16 = 32'd65536;
  localparam logic [31:0] LIMIT_8  = 32'd256;

  // Register map.
  localparam logic [1:0] ADDR_TIMER_KIND = 2'd0;

  // Control that travels along the divider chain with each transaction.
  typedef struct packed {
    logic valid;
    logic off;
    logic kind;
  } tps_ctl_t;

  // All divisors are powers of two, so a divisor is a right shift of the
  // half-period count of divisor one.
  function automatic logic [3:0] shift_16(input logic [CODE_W-1:0] code);
    logic [3:0] sh;
    unique case (code)
      4'd1:    sh = 4'd0;
      4'd2:    sh = 4'd3;
      4'd3:    sh = 4'd6;
      4'd4:    sh = 4'd8;
      4'd5:    sh = 4'd10;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

  function automatic logic [3:0] shift_8(input logic [CODE_W-1:0] code);
    logic [3:0] sh;
    unique case (code)
      4'd1:    sh = 4'd0;
      4'd2:    sh = 4'd3;
      4'd3:    sh = 4'd5;
      4'd4:    sh = 4'd6;
      4'd5:    sh = 4'd7;
      4'd6:    sh = 4'd8;
      4'd7:    sh = 4'd10;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tps_div_cell.sv
// ----------------------------------------------------------------------------
// tps_div_cell
// One cell of the restoring divider chain: brings in one bit of the constant
// clock rate, produces one quotient bit and hands everything on.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_div_cell #(
  parameter int unsigned QW      = 24,
  parameter bit          DVD_BIT = 1'b0
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  tps_pkg::tps_ctl_t                  ctl_i,
  input  wire [tps_pkg::DVSR_W-1:0]          dvsr_i,
  input  wire [tps_pkg::DVSR_W-1:0]          rem_i,
  input  wire [QW-1:0]                       quo_i,
  output tps_pkg::tps_ctl_t                  ctl_o,
  output logic [tps_pkg::DVSR_W-1:0]         dvsr_o,
  output logic [tps_pkg::DVSR_W-1:0]         rem_o,
  output logic [QW-1:0]                      quo_o
);

  tps_pkg::tps_ctl_t                 ctl_r;
  logic [tps_pkg::DVSR_W-1:0]        dvsr_r;
  logic [tps_pkg::DVSR_W-1:0]        rem_r, rem_nxt;
  logic [QW-1:0]                     quo_r, quo_nxt;
  logic [tps_pkg::DVSR_W:0]          trial;
  logic [tps_pkg::DVSR_W:0]          diff;

  // Shift in the next dividend bit and subtract where the divisor fits.
  always_comb begin
    trial = {rem_i, DVD_BIT};
    diff  = trial - {1'b0, dvsr_i};
    if (trial >= {1'b0, dvsr_i}) begin
      rem_nxt = diff[tps_pkg::DVSR_W-1:0];
      quo_nxt = {quo_i[QW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[tps_pkg::DVSR_W-1:0];
      quo_nxt = {quo_i[QW-2:0], 1'b0};
    end
  end

  // Only the valid flag needs a reset; the data simply follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.off  <= ctl_i.off;
    ctl_r.kind <= ctl_i.kind;
    dvsr_r     <= dvsr_i;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
  end

  assign ctl_o  = ctl_r;
  assign dvsr_o = dvsr_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;

endmodule

`default_nettype wire

### hw/rtl/tps_select.sv
// ----------------------------------------------------------------------------
// tps_select
// Picks the smallest prescaler whose count fits the timer, or the stop code
// for an off request, and registers the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_select #(
  parameter int unsigned QW = 24
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  tps_pkg::tps_ctl_t                  ctl_i,
  input  wire [QW-1:0]                       quo_i,
  output logic                               strobe_o,
  output logic [tps_pkg::CODE_W-1:0]         code_o,
  output logic [tps_pkg::CMP_W-1:0]          cmp_o,
  output logic                               too_low_o
);

  logic                          strobe_r;
  logic [tps_pkg::CODE_W-1:0]    code_r, code_nxt;
  logic [tps_pkg::CMP_W-1:0]     cmp_r, cmp_nxt;
  logic                          too_low_r, too_low_nxt;
  logic [tps_pkg::CODE_W-1:0]    n_codes;
  logic [31:0]                   limit;
  logic [31:0]                   base;
  logic [31:0]                   cnt;
  logic [31:0]                   cnt_sel;
  logic [31:0]                   cnt_m1;
  logic [3:0]                    sh;
  logic                          found;

  // Scan the codes from the top down so that the smallest fitting one wins.
  always_comb begin
    n_codes  = ctl_i.kind ? tps_pkg::TABLE_SIZE_8 : tps_pkg::TABLE_SIZE_16;
    limit    = ctl_i.kind ? tps_pkg::LIMIT_8 : tps_pkg::LIMIT_16;
    base     = 32'(quo_i);
    code_nxt = n_codes;
    sh       = ctl_i.kind ? tps_pkg::shift_8(4'd7) : tps_pkg::shift_16(4'd5);
    cnt_sel  = base >> sh;
    found    = 1'b0;
    for (int c = 7; c >= 1; c--) begin
      sh  = ctl_i.kind ? tps_pkg::shift_8(4'(c)) : tps_pkg::shift_16(4'(c));
      cnt = base >> sh;
      if ((4'(c) < n_codes) && (cnt <= limit)) begin
        code_nxt = 4'(c);
        cnt_sel  = cnt;
        found    = 1'b1;
      end
    end
    if (ctl_i.off) begin
      code_nxt = tps_pkg::CODE_STOP;
      cnt_sel  = 32'd0;
    end
    too_low_nxt = !ctl_i.off && !found;
    cnt_m1      = cnt_sel - 32'd1;
    cmp_nxt     = ctl_i.kind ? {8'h00, cnt_m1[7:0]} : cnt_m1[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    cmp_r     <= cmp_nxt;
    too_low_r <= too_low_nxt;
  end

  assign strobe_o  = strobe_r;
  assign code_o    = code_r;
  assign cmp_o     = cmp_r;
  assign too_low_o = too_low_r;

endmodule

`default_nettype wire

### hw/rtl/tone_prescale_select.sv
// ----------------------------------------------------------------------------
// tone_prescale_select
// Works out the prescaler code and compare value that make a compare-match
// timer toggle a pin at a requested tone frequency.
// ----------------------------------------------------------------------------
// Usage: drive in_tone_freq and raise start for one cycle; the transaction is
// taken at that edge, as busy is always low. A new frequency may be offered
// in every cycle. The half-period count for divisor one, CLOCK_HZ over twice
// the frequency, comes out of a row of restoring divider cells, one cell per
// quotient bit; every other divisor is a power of two and so a shift of that
// count. A final stage picks the smallest prescaler that fits and registers
// the result.
// A request passes the divider cells and then the select register to reach
// out_strobe. QW, the quotient width, is the bit width of CLOCK_HZ.
// The block takes one transaction per cycle, set by the divider chain.
// The result stands on the out_ ports for the single cycle in which
// out_strobe is high; the receiver cannot stall it. Reset clears timer_kind to
// the 16-bit table and drops every transaction in flight. The user must write
// timer_kind over the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_prescale_select #(
  parameter int unsigned CLOCK_HZ = 16000000
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input channel
  input  wire                                start,
  output logic                               busy,
  input  wire signed [14:0]                  in_tone_freq,
  // Result channel
  output logic                               out_strobe,
  output logic [3:0]                         out_prescale_code,
  output logic [15:0]                        out_compare_value,
  output logic                               out_too_low,
  // Configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [1:0]                          paddr,
  input  wire [31:0]                         pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned QW = $clog2(CLOCK_HZ + 1);
  localparam logic [QW-1:0] DVD = QW'(CLOCK_HZ);

  logic                        timer_kind_r, timer_kind_nxt;
  tps_pkg::tps_ctl_t           ctl   [0:QW];
  logic [tps_pkg::DVSR_W-1:0]  dvsr  [0:QW];
  logic [tps_pkg::DVSR_W-1:0]  rem   [0:QW];
  logic [QW-1:0]               quo   [0:QW];

  // Configuration register.
  always_comb begin
    timer_kind_nxt = timer_kind_r;
    if (psel && penable && pwrite && (paddr == tps_pkg::ADDR_TIMER_KIND)) begin
      timer_kind_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_kind_r <= 1'b0;
    end else begin
      timer_kind_r <= timer_kind_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == tps_pkg::ADDR_TIMER_KIND) ? {31'd0, timer_kind_r} : 32'd0;
  assign busy   = 1'b0;

  // Head of the chain: an off request still flows through, with divisor one.
  always_comb begin
    ctl[0].valid = start;
    ctl[0].off   = in_tone_freq[14] || (in_tone_freq == 15'sd0);
    ctl[0].kind  = timer_kind_r;
    dvsr[0]      = ctl[0].off ? 15'd1 : {in_tone_freq[13:0], 1'b0};
    rem[0]       = '0;
    quo[0]       = '0;
  end

  // Divider cells, most significant dividend bit first.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    tps_div_cell #(
      .QW      (QW),
      .DVD_BIT (DVD[QW-1-i])
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl[i]),
      .dvsr_i (dvsr[i]),
      .rem_i  (rem[i]),
      .quo_i  (quo[i]),
      .ctl_o  (ctl[i+1]),
      .dvsr_o (dvsr[i+1]),
      .rem_o  (rem[i+1]),
      .quo_o  (quo[i+1])
    );
  end

  // Prescaler choice and output register.
  tps_select #(
    .QW (QW)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl[QW]),
    .quo_i     (quo[QW]),
    .strobe_o  (out_strobe),
    .code_o    (out_prescale_code),
    .cmp_o     (out_compare_value),
    .too_low_o (out_too_low)
  );

endmodule

`default_nettype wire
